// ===== rtl/terminal_screen_edit_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Terminal screen edit engine assertion macros
// Shared macro forms for the concurrent assertions of the engine's checker.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_SCREEN_EDIT_ENGINE_ASSERT_SVH
`define TERMINAL_SCREEN_EDIT_ENGINE_ASSERT_SVH

// Same-cycle implication, switched off while reset is applied.
`define TSE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is applied.
`define TSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TSE_ASSERT_NEXT_ANY(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// Terminal screen edit engine package
// Item types, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

    localparam logic [6:0] ROWS_RESET = 7'd24;
    localparam logic [7:0] COLS_RESET = 8'd80;

    localparam logic [3:0] KIND_CR         = 4'd0;
    localparam logic [3:0] KIND_BS         = 4'd1;
    localparam logic [3:0] KIND_TAB        = 4'd2;
    localparam logic [3:0] KIND_ERASE_DISP = 4'd3;
    localparam logic [3:0] KIND_ERASE_LINE = 4'd4;
    localparam logic [3:0] KIND_SET_REGION = 4'd5;
    localparam logic [3:0] KIND_RST_REGION = 4'd6;
    localparam logic [3:0] KIND_INDEX      = 4'd7;
    localparam logic [3:0] KIND_REV_INDEX  = 4'd8;
    localparam logic [3:0] KIND_WRITE      = 4'd9;
    localparam logic [3:0] KIND_READ       = 4'd10;
    localparam logic [3:0] KIND_SET_CURSOR = 4'd11;
    localparam logic [3:0] KIND_MARK_WRAP  = 4'd12;

    localparam logic [1:0] MODE_TO_END   = 2'd0;
    localparam logic [1:0] MODE_TO_START = 2'd1;
    localparam logic [1:0] MODE_ALL      = 2'd2;
    localparam logic [1:0] MODE_ALL_SB   = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  mode;
        logic [5:0]  row_arg;
        logic [5:0]  bottom_arg;
        logic [6:0]  col_arg;
        logic [15:0] cell_value;
    } tse_in_t;

    typedef struct packed {
        logic [5:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        wrap_pending;
        logic [5:0]  region_top;
        logic [5:0]  region_bottom;
        logic [15:0] read_value;
        logic        line_to_scrollback;
        logic        scrollback_cleared;
    } tse_out_t;

    typedef struct packed {
        logic latch_item;
        logic start_sweep;
        logic sweep_step;
        logic read_capture;
        logic commit;
    } tse_cmd_t;

    typedef struct packed {
        logic need_sweep;
        logic need_read;
        logic sweep_last;
    } tse_status_t;

endpackage

// ===== rtl/tse_ctrl.sv =====
// ----------------------------------------------------------------------------
// Terminal screen edit engine controller
// Sequences the clearing pass, item intake, grid sweeps, reads and results.
// ----------------------------------------------------------------------------
module tse_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  tse_pkg::tse_status_t status,
    output tse_pkg::tse_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_READ,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd              = '0;
        cmd.latch_item   = (state_reg == ST_IDLE) && s_valid;
        cmd.start_sweep  = (state_reg == ST_EXEC) && status.need_sweep;
        cmd.sweep_step   = (state_reg == ST_INIT) || (state_reg == ST_SWEEP);
        cmd.read_capture = (state_reg == ST_READ);
        cmd.commit       = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    if (status.sweep_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (status.need_sweep) begin
                        state_reg <= ST_SWEEP;
                    end else if (status.need_read) begin
                        state_reg <= ST_READ;
                    end else begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_SWEEP: begin
                    if (status.sweep_last) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/tse_datapath.sv =====
// ----------------------------------------------------------------------------
// Terminal screen edit engine datapath
// Cell grid memory, sweep counters, cursor and region state, result register.
// ----------------------------------------------------------------------------
module tse_datapath #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 128,
    parameter int CELL_BITS = 16,
    parameter int TAB_STOP  = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tse_pkg::tse_cmd_t                cmd,
    output tse_pkg::tse_status_t             status,
    input  tse_pkg::tse_in_t                 s_data,
    output tse_pkg::tse_out_t                m_data,
    input  logic                             cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NTAB  = MAX_COLS / TAB_STOP + 1;
    localparam int TW    = $clog2(MAX_COLS + 2 * TAB_STOP + 1);
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);

    typedef enum logic [1:0] {
        SW_CLR_ALL,
        SW_CLR_MASK,
        SW_SCROLL
    } sw_op_t;

    function automatic logic [NRW-1:0] clamp_rows(input logic [6:0] v);
        if (v == 7'd0) return NRW'(1);
        if (32'(v) > MAX_ROWS) return NRW'(MAX_ROWS);
        return NRW'(v);
    endfunction

    function automatic logic [NCW-1:0] clamp_cols(input logic [7:0] v);
        if (v == 8'd0) return NCW'(1);
        if (32'(v) > MAX_COLS) return NCW'(MAX_COLS);
        return NCW'(v);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
    endfunction

    logic [CELL_BITS-1:0] grid_mem [DEPTH];
    logic [CELL_BITS-1:0] rdata_reg;

    tse_pkg::tse_in_t  item_reg;
    tse_pkg::tse_out_t out_reg, out_next;

    logic [6:0]     rows_reg, rows_next;
    logic [7:0]     cols_reg, cols_next;
    logic [RW-1:0]  cur_row_reg, cur_row_next;
    logic [CW-1:0]  cur_col_reg, cur_col_next;
    logic           wrap_reg, wrap_next;
    logic [RW-1:0]  top_reg, top_next;
    logic [RW-1:0]  bot_reg, bot_next;
    logic [CELL_BITS-1:0] rd_reg;

    sw_op_t         sw_op_reg;
    logic           sw_down_reg;
    logic           sw_phase_reg;
    logic [RW-1:0]  sw_row_reg, sw_end_reg, sw_rs_reg, sw_re_reg;
    logic [CW-1:0]  sw_col_reg, sw_cs_reg, sw_ce_reg;

    logic [NRW-1:0] nr;
    logic [NCW-1:0] nc;
    logic [RW-1:0]  nr_m1, cfg_nr_m1, sw_src_row, sw_row_step;
    logic [CW-1:0]  nc_m1, cfg_nc_m1;
    logic           item_in_range, sw_at_end, mask_ok;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [CELL_BITS-1:0] mem_wdata;
    logic [TW-1:0]  tab_t;

    assign nr        = clamp_rows(rows_reg);
    assign nc        = clamp_cols(cols_reg);
    assign nr_m1     = RW'(nr - NRW'(1));
    assign nc_m1     = CW'(nc - NCW'(1));
    assign cfg_nr_m1 = RW'(clamp_rows(cfg_data[6:0]) - NRW'(1));
    assign cfg_nc_m1 = CW'(clamp_cols(cfg_data[7:0]) - NCW'(1));

    assign item_in_range = (NRW'(item_reg.row_arg) < nr) && (NCW'(item_reg.col_arg) < nc);

    assign sw_at_end = (sw_row_reg == sw_end_reg);

    // Decode of the latched item and sweep progress for the controller.
    always_comb begin
        status = '0;
        case (item_reg.kind)
            tse_pkg::KIND_ERASE_DISP: status.need_sweep = 1'b1;
            tse_pkg::KIND_ERASE_LINE: begin
                status.need_sweep = (item_reg.mode != tse_pkg::MODE_ALL_SB);
            end
            tse_pkg::KIND_INDEX:      status.need_sweep = (cur_row_reg == bot_reg);
            tse_pkg::KIND_REV_INDEX:  status.need_sweep = (cur_row_reg == top_reg);
            default:                  status.need_sweep = 1'b0;
        endcase
        status.need_read  = (item_reg.kind == tse_pkg::KIND_READ) && item_in_range;
        status.sweep_last = sw_at_end && (sw_col_reg == COL_LAST)
                            && !((sw_op_reg == SW_SCROLL) && !sw_at_end);
    end

    assign sw_row_step = sw_down_reg ? RW'(sw_row_reg - RW'(1)) : RW'(sw_row_reg + RW'(1));
    assign sw_src_row  = sw_row_step;
    assign mask_ok     = (NCW'(sw_col_reg) < nc)
                         && ((sw_row_reg != sw_rs_reg) || (sw_col_reg >= sw_cs_reg))
                         && ((sw_row_reg != sw_re_reg) || (sw_col_reg <= sw_ce_reg));

    // Grid port selection: sweep traffic, or the single write of a write item.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr(sw_row_reg, sw_col_reg);
        mem_wdata = '0;
        mem_raddr = cell_addr(RW'(item_reg.row_arg), CW'(item_reg.col_arg));
        if (cmd.sweep_step) begin
            case (sw_op_reg)
                SW_CLR_ALL:  mem_we = 1'b1;
                SW_CLR_MASK: mem_we = mask_ok;
                SW_SCROLL: begin
                    mem_raddr = cell_addr(sw_src_row, sw_col_reg);
                    mem_we    = sw_at_end || sw_phase_reg;
                    mem_wdata = sw_at_end ? '0 : rdata_reg;
                end
                default: mem_we = 1'b0;
            endcase
        end else if (cmd.commit && (item_reg.kind == tse_pkg::KIND_WRITE) && item_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(RW'(item_reg.row_arg), CW'(item_reg.col_arg));
            mem_wdata = CELL_BITS'(item_reg.cell_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= grid_mem[mem_raddr];
    end

    // Next tab stop: the smallest multiple of the stop above the cursor.
    always_comb begin
        tab_t = TW'(NTAB * TAB_STOP);
        for (int k = NTAB; k >= 1; k--) begin
            if (TW'(k * TAB_STOP) > TW'(cur_col_reg)) begin
                tab_t = TW'(k * TAB_STOP);
            end
        end
    end

    // Cursor, region and result for the item being committed, then config.
    always_comb begin
        logic [RW-1:0] ra;
        logic [RW-1:0] rb;
        rows_next    = rows_reg;
        cols_next    = cols_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        wrap_next    = wrap_reg;
        top_next     = top_reg;
        bot_next     = bot_reg;
        out_next     = out_reg;
        ra           = (item_reg.row_arg > nr_m1) ? nr_m1 : RW'(item_reg.row_arg);
        rb           = (item_reg.bottom_arg > nr_m1) ? nr_m1 : RW'(item_reg.bottom_arg);
        if (cmd.commit) begin
            out_next.line_to_scrollback = 1'b0;
            out_next.scrollback_cleared = 1'b0;
            case (item_reg.kind)
                tse_pkg::KIND_CR: begin
                    cur_col_next = '0;
                    wrap_next    = 1'b0;
                end
                tse_pkg::KIND_BS: begin
                    if (wrap_reg) begin
                        wrap_next = 1'b0;
                    end else if (cur_col_reg != '0) begin
                        cur_col_next = CW'(cur_col_reg - CW'(1));
                    end
                end
                tse_pkg::KIND_TAB: begin
                    cur_col_next = (tab_t < TW'(nc_m1)) ? CW'(tab_t) : nc_m1;
                    wrap_next    = 1'b0;
                end
                tse_pkg::KIND_ERASE_DISP: begin
                    if (item_reg.mode == tse_pkg::MODE_ALL || item_reg.mode == tse_pkg::MODE_ALL_SB) begin
                        wrap_next = 1'b0;
                        out_next.scrollback_cleared = (item_reg.mode == tse_pkg::MODE_ALL_SB);
                    end
                end
                tse_pkg::KIND_SET_REGION: begin
                    top_next     = (rb < ra) ? rb : ra;
                    bot_next     = (rb < ra) ? ra : rb;
                    cur_row_next = (rb < ra) ? rb : ra;
                    cur_col_next = '0;
                    wrap_next    = 1'b0;
                end
                tse_pkg::KIND_RST_REGION: begin
                    top_next = '0;
                    bot_next = nr_m1;
                end
                tse_pkg::KIND_INDEX: begin
                    if (cur_row_reg == bot_reg) begin
                        out_next.line_to_scrollback = (top_reg == '0) && (bot_reg == nr_m1);
                    end else if (cur_row_reg < nr_m1) begin
                        cur_row_next = RW'(cur_row_reg + RW'(1));
                    end
                    wrap_next = 1'b0;
                end
                tse_pkg::KIND_REV_INDEX: begin
                    if ((cur_row_reg != top_reg) && (cur_row_reg != '0)) begin
                        cur_row_next = RW'(cur_row_reg - RW'(1));
                    end
                    wrap_next = 1'b0;
                end
                tse_pkg::KIND_SET_CURSOR: begin
                    cur_row_next = (item_reg.row_arg < nr_m1) ? RW'(item_reg.row_arg) : nr_m1;
                    cur_col_next = (item_reg.col_arg < nc_m1) ? CW'(item_reg.col_arg) : nc_m1;
                    wrap_next    = 1'b0;
                end
                tse_pkg::KIND_MARK_WRAP: begin
                    wrap_next = 1'b1;
                end
                default: begin
                    wrap_next = wrap_reg;
                end
            endcase
            out_next.cursor_row    = 6'(cur_row_next);
            out_next.cursor_col    = 7'(cur_col_next);
            out_next.wrap_pending  = wrap_next;
            out_next.region_top    = 6'(top_next);
            out_next.region_bottom = 6'(bot_next);
            out_next.read_value    = 16'(rd_reg);
        end
        if (cfg_we) begin
            case (cfg_index)
                tse_pkg::CFG_ROWS: begin
                    rows_next = cfg_data[6:0];
                    top_next  = '0;
                    bot_next  = cfg_nr_m1;
                    if (cur_row_next > cfg_nr_m1) begin
                        cur_row_next = cfg_nr_m1;
                    end
                end
                tse_pkg::CFG_COLS: begin
                    cols_next = cfg_data[7:0];
                    if (cur_col_next > cfg_nc_m1) begin
                        cur_col_next = cfg_nc_m1;
                    end
                end
                default: begin
                    rows_next = rows_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg     <= tse_pkg::ROWS_RESET;
            cols_reg     <= tse_pkg::COLS_RESET;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            wrap_reg     <= 1'b0;
            top_reg      <= '0;
            bot_reg      <= RW'(clamp_rows(tse_pkg::ROWS_RESET) - NRW'(1));
            sw_op_reg    <= SW_CLR_ALL;
            sw_down_reg  <= 1'b0;
            sw_phase_reg <= 1'b0;
            sw_row_reg   <= '0;
            sw_col_reg   <= '0;
            sw_end_reg   <= ROW_LAST;
        end else begin
            rows_reg    <= rows_next;
            cols_reg    <= cols_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            wrap_reg    <= wrap_next;
            top_reg     <= top_next;
            bot_reg     <= bot_next;
            if (cmd.start_sweep) begin
                sw_phase_reg <= 1'b0;
                sw_col_reg   <= '0;
                sw_down_reg  <= 1'b0;
                sw_op_reg    <= SW_CLR_MASK;
                sw_row_reg   <= cur_row_reg;
                sw_end_reg   <= cur_row_reg;
                case (item_reg.kind)
                    tse_pkg::KIND_ERASE_DISP: begin
                        if (item_reg.mode == tse_pkg::MODE_TO_END) begin
                            sw_end_reg <= nr_m1;
                        end else if (item_reg.mode == tse_pkg::MODE_TO_START) begin
                            sw_row_reg <= '0;
                        end else begin
                            sw_op_reg  <= SW_CLR_ALL;
                            sw_row_reg <= '0;
                            sw_end_reg <= ROW_LAST;
                        end
                    end
                    tse_pkg::KIND_INDEX: begin
                        sw_op_reg  <= SW_SCROLL;
                        sw_row_reg <= top_reg;
                        sw_end_reg <= bot_reg;
                    end
                    tse_pkg::KIND_REV_INDEX: begin
                        sw_op_reg   <= SW_SCROLL;
                        sw_down_reg <= 1'b1;
                        sw_row_reg  <= bot_reg;
                        sw_end_reg  <= top_reg;
                    end
                    default: begin
                        sw_op_reg <= SW_CLR_MASK;
                    end
                endcase
            end else if (cmd.sweep_step) begin
                if ((sw_op_reg == SW_SCROLL) && !sw_at_end && !sw_phase_reg) begin
                    sw_phase_reg <= 1'b1;
                end else begin
                    sw_phase_reg <= 1'b0;
                    if (sw_col_reg == COL_LAST) begin
                        sw_col_reg <= '0;
                        if (!sw_at_end) begin
                            sw_row_reg <= sw_row_step;
                        end
                    end else begin
                        sw_col_reg <= CW'(sw_col_reg + CW'(1));
                    end
                end
            end
        end
    end

    // Masked-erase bounds; only the erase kinds read them.
    always_ff @(posedge aclk) begin
        if (cmd.start_sweep) begin
            sw_rs_reg <= cur_row_reg;
            sw_re_reg <= cur_row_reg;
            sw_cs_reg <= '0;
            sw_ce_reg <= nc_m1;
            if (item_reg.kind == tse_pkg::KIND_ERASE_DISP) begin
                if (item_reg.mode == tse_pkg::MODE_TO_END) begin
                    sw_cs_reg <= cur_col_reg;
                    sw_re_reg <= nr_m1;
                end else begin
                    sw_rs_reg <= '0;
                    sw_ce_reg <= cur_col_reg;
                end
            end else if (item_reg.mode == tse_pkg::MODE_TO_END) begin
                sw_cs_reg <= cur_col_reg;
            end else if (item_reg.mode == tse_pkg::MODE_TO_START) begin
                sw_ce_reg <= cur_col_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            item_reg <= s_data;
            rd_reg   <= '0;
        end else if (cmd.read_capture) begin
            rd_reg <= rdata_reg;
        end
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

// ===== rtl/terminal_screen_edit_engine.sv =====
// ----------------------------------------------------------------------------
// Terminal screen edit engine
// Cell grid with cursor, pending wrap and scroll region, driven by one
// control command per item.
// ----------------------------------------------------------------------------
// Usage: command items enter on s_valid/s_ready with payload s_data, and one
// result item per command leaves on m_valid/m_ready with payload m_data.
// The two size registers are written through cfg_valid/cfg_ready, which is
// always ready; write them only while no command is in flight.
// After reset the engine clears the whole grid, one cell per cycle, with
// s_ready low. A command without grid work passes through the execute and
// output states, where its result is registered, and the controller then
// returns to idle to take the next item. A read adds a read state for the
// grid memory's registered read port. Erase in line sweeps the cursor row
// (mode MODE_ALL_SB does no grid work), erase in display the rows it covers
// (whole grid for the full modes), and a scroll the region rows, where each
// cell copy takes a read step and a write step on the single grid memory.
// The result sits in an output register, so the next item is taken while
// a result waits; when the receiver stalls, the engine finishes the item in
// hand and holds in its final step until the output register is free.
// ----------------------------------------------------------------------------
module terminal_screen_edit_engine #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_COLS  = 128,
    parameter int CELL_BITS = 16,
    parameter int TAB_STOP  = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tse_pkg::tse_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tse_pkg::tse_out_t              m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tse_pkg::CFG_DATA_W-1:0] cfg_data
);

    tse_pkg::tse_cmd_t    cmd;
    tse_pkg::tse_status_t status;

    // Register writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    // The controller owns the handshakes and the order of the grid work.
    tse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the grid, the cursor state and the result register.
    tse_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS),
        .TAB_STOP  (TAB_STOP)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/tse_checker.sv =====
// ----------------------------------------------------------------------------
// Terminal screen edit engine checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "terminal_screen_edit_engine_assert.svh"

module tse_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input tse_pkg::tse_out_t m_data
);

    // No result is offered in the cycle after reset.
    `TSE_ASSERT_NEXT_ANY(a_no_result_after_reset, !aresetn, !m_valid, "result valid after reset")

    // A stalled result keeps its contents.
    `TSE_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")

    // One item at a time: intake closes right after an item is taken.
    `TSE_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second item taken while busy")

    // The region never inverts.
    `TSE_ASSERT_NOW(a_region_order, m_valid, m_data.region_top <= m_data.region_bottom, "region inverted")

    // Only a full-screen scroll pushes a line out; this checks that the region starts at row 0.
    `TSE_ASSERT_NOW(a_push_full_screen, m_valid && m_data.line_to_scrollback, m_data.region_top == 6'd0, "push with partial region")

endmodule

bind terminal_screen_edit_engine tse_checker u_tse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
